>>> sv/png_chunk_crc_validator_core_defines.svh
// assertion macros for the png chunk crc validator
`ifndef PNG_CHUNK_CRC_VALIDATOR_CORE_DEFINES_SVH
`define PNG_CHUNK_CRC_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pcv_pkg.sv
// constants, verdict codes and crc-32 byte update for the png chunk crc validator
package pcv_pkg;

    typedef logic [2:0] reason_t;

    localparam reason_t REASON_OK       = 3'd0;
    localparam reason_t REASON_BAD_SIG  = 3'd1;
    localparam reason_t REASON_CRC_FAIL = 3'd2;
    localparam reason_t REASON_NO_IEND  = 3'd3;
    localparam reason_t REASON_NO_IHDR  = 3'd4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    // IHDR
    function automatic logic [7:0] hdr_name_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h48;
            2'd2:    b = 8'h44;
            default: b = 8'h52;
        endcase
        return b;
    endfunction

    // IEND
    function automatic logic [7:0] end_name_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h45;
            2'd2:    b = 8'h4E;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/png_chunk_crc_validator_core.sv
// png signature and chunk crc-32 checker with one verdict per file
//
//  channel | dir | tdata (low bit up)                      | tlast
//  s_      | in  | data_byte[7:0]                          | last_byte
//  m_      | out | is_png[0], reason[3:1], zero pad [7:4]  | -
//
// one byte is taken every cycle while the input is not held off; the crc-32 byte
// update and the parser step sit between the state registers and the output register
// a verdict appears in the cycle after the transaction that carries tlast
// the input is held off only while an undelivered verdict waits on m_tready
// aresetn is synchronous, active low, and returns the parser to the signature check
`include "png_chunk_crc_validator_core_defines.svh"

module png_chunk_crc_validator_core
    import pcv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // is_png[0], reason[3:1], zero [7:4]
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [2:0]  field_cnt_reg,  field_cnt_next;
    logic [31:0] chunk_len_reg,  chunk_len_next;
    logic [31:0] run_crc_reg,    run_crc_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic        is_hdr_reg,     is_hdr_next;
    logic        is_end_reg,     is_end_next;
    logic        seen_hdr_reg,   seen_hdr_next;
    reason_t     verdict_reg,    verdict_next;
    logic        m_tvalid_reg,   m_tvalid_next;
    logic [7:0]  m_tdata_reg,    m_tdata_next;

    logic        s_accept;
    logic [1:0]  k2;
    logic [31:0] len_dec;
    logic [31:0] stored_crc_shift;
    reason_t     code;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign k2               = field_cnt_reg[1:0];
    assign len_dec          = chunk_len_reg - 32'd1;
    assign stored_crc_shift = {stored_crc_reg[23:0], s_tdata};

    always_comb begin
        phase_next      = phase_reg;
        field_cnt_next  = field_cnt_reg;
        chunk_len_next  = chunk_len_reg;
        run_crc_next    = run_crc_reg;
        stored_crc_next = stored_crc_reg;
        is_hdr_next     = is_hdr_reg;
        is_end_next     = is_end_reg;
        seen_hdr_next   = seen_hdr_reg;
        verdict_next    = verdict_reg;
        code            = verdict_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        if (s_accept) begin
            case (phase_reg)
                PH_SIG: begin
                    if (s_tdata != sig_byte(field_cnt_reg)) begin
                        phase_next   = PH_FAIL;
                        verdict_next = REASON_BAD_SIG;
                    end else if (field_cnt_reg == 3'd7) begin
                        phase_next     = PH_LEN;
                        field_cnt_next = 3'd0;
                    end else begin
                        field_cnt_next = field_cnt_reg + 3'd1;
                    end
                end
                PH_LEN: begin
                    chunk_len_next = {chunk_len_reg[23:0], s_tdata};
                    if (k2 == 2'd3) begin
                        phase_next     = PH_TYPE;
                        field_cnt_next = 3'd0;
                        run_crc_next   = CRC_INIT;
                    end else begin
                        field_cnt_next = field_cnt_reg + 3'd1;
                    end
                end
                PH_TYPE: begin
                    run_crc_next = crc32_byte(run_crc_reg, s_tdata);
                    if (k2 == 2'd0) begin
                        is_hdr_next = (s_tdata == hdr_name_byte(k2));
                        is_end_next = (s_tdata == end_name_byte(k2));
                    end else begin
                        is_hdr_next = is_hdr_reg && (s_tdata == hdr_name_byte(k2));
                        is_end_next = is_end_reg && (s_tdata == end_name_byte(k2));
                    end
                    if (k2 == 2'd3) begin
                        field_cnt_next = 3'd0;
                        phase_next     = (chunk_len_reg == 32'd0) ? PH_CRC : PH_DATA;
                    end else begin
                        field_cnt_next = field_cnt_reg + 3'd1;
                    end
                end
                PH_DATA: begin
                    run_crc_next   = crc32_byte(run_crc_reg, s_tdata);
                    chunk_len_next = len_dec;
                    if (len_dec == 32'd0) begin
                        phase_next     = PH_CRC;
                        field_cnt_next = 3'd0;
                    end
                end
                PH_CRC: begin
                    stored_crc_next = stored_crc_shift;
                    if (k2 == 2'd3) begin
                        field_cnt_next = 3'd0;
                        if ((run_crc_reg ^ CRC_INIT) != stored_crc_shift) begin
                            phase_next   = PH_FAIL;
                            verdict_next = REASON_CRC_FAIL;
                        end else begin
                            if (is_hdr_reg) begin
                                seen_hdr_next = 1'b1;
                            end
                            if (is_end_reg) begin
                                phase_next   = PH_DONE;
                                verdict_next = (seen_hdr_reg || is_hdr_reg) ?
                                               REASON_OK : REASON_NO_IHDR;
                            end else begin
                                phase_next      = PH_LEN;
                                chunk_len_next  = 32'd0;
                                stored_crc_next = 32'd0;
                            end
                        end
                    end else begin
                        field_cnt_next = field_cnt_reg + 3'd1;
                    end
                end
                default: begin
                end
            endcase

            case (phase_next)
                PH_SIG:  code = REASON_BAD_SIG;
                PH_LEN,
                PH_TYPE,
                PH_DATA,
                PH_CRC:  code = REASON_NO_IEND;
                default: code = verdict_next;
            endcase

            if (s_tlast) begin
                m_tvalid_next   = 1'b1;
                m_tdata_next    = {4'd0, code, (code == REASON_OK)};
                phase_next      = PH_SIG;
                field_cnt_next  = 3'd0;
                chunk_len_next  = 32'd0;
                run_crc_next    = CRC_INIT;
                stored_crc_next = 32'd0;
                is_hdr_next     = 1'b0;
                is_end_next     = 1'b0;
                seen_hdr_next   = 1'b0;
                verdict_next    = REASON_NO_IEND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIG;
            field_cnt_reg  <= 3'd0;
            chunk_len_reg  <= 32'd0;
            run_crc_reg    <= CRC_INIT;
            stored_crc_reg <= 32'd0;
            is_hdr_reg     <= 1'b0;
            is_end_reg     <= 1'b0;
            seen_hdr_reg   <= 1'b0;
            verdict_reg    <= REASON_NO_IEND;
            m_tvalid_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            field_cnt_reg  <= field_cnt_next;
            chunk_len_reg  <= chunk_len_next;
            run_crc_reg    <= run_crc_next;
            stored_crc_reg <= stored_crc_next;
            is_hdr_reg     <= is_hdr_next;
            is_end_reg     <= is_end_next;
            seen_hdr_reg   <= seen_hdr_next;
            verdict_reg    <= verdict_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    // verdict bit agrees with the reason code
    `PCV_ASSERT_SAME(a_is_png_match, m_tvalid, m_tdata[0] == (m_tdata[3:1] == REASON_OK), "is_png disagrees with reason")
    // reason code stays in its range
    `PCV_ASSERT_SAME(a_reason_range, m_tvalid, m_tdata[3:1] <= REASON_NO_IHDR, "reason code out of range")
    // a final byte always yields a verdict and restarts the parser
    `PCV_ASSERT_NEXT(a_last_restart, s_accept && s_tlast, m_tvalid_reg && phase_reg == PH_SIG && run_crc_reg == CRC_INIT, "no restart after final byte")
    // a non-final byte never creates a verdict by itself
    `PCV_ASSERT_NEXT(a_no_spurious, !m_tvalid_reg && !(s_accept && s_tlast), !m_tvalid_reg, "verdict without final byte")

endmodule

>>> test/tb_top.sv
// testbench for png_chunk_crc_validator_core: png files streamed byte by byte, verdicts checked
`timescale 1ns / 100ps

module tb_top;
    import pcv_pkg::*;

    typedef enum logic [2:0] {
        ST_SIG, ST_LEN, ST_TYPE, ST_DATA, ST_CRC, ST_DONE, ST_FAIL
    } parse_phase_e;

    typedef struct packed {
        logic    is_png;
        reason_t reason;
    } verdict_t;

    localparam logic [63:0] PNG_SIG   = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] NAME_IHDR = 32'h4948_4452;
    localparam logic [31:0] NAME_IEND = 32'h4945_4E44;
    localparam logic [31:0] NAME_IDAT = 32'h4944_4154;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    // parser state of the predictor
    parse_phase_e pp_phase;
    logic [2:0]   pp_cnt;
    logic [31:0]  pp_len;
    logic [31:0]  pp_crc;
    logic [31:0]  pp_stored;
    logic         pp_is_hdr;
    logic         pp_is_end;
    logic         pp_seen_hdr;
    reason_t      pp_code;

    verdict_t     verdict_q[$];
    logic [7:0]   file_bytes[$];
    int unsigned  error_count   = 0;
    int unsigned  live_bytes    = 0;
    int unsigned  rx_hold_cycles = 0;
    bit           tx_gaps_on    = 1'b1;
    bit           rx_stalls_on  = 1'b1;

    png_chunk_crc_validator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[png_chunk_crc_validator_core] ERROR");
        $finish;
    end

    function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'h0, d};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic append_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    task automatic parser_clear();
        pp_phase    = ST_SIG;
        pp_cnt      = 3'd0;
        pp_len      = 32'd0;
        pp_crc      = CRC_INIT;
        pp_stored   = 32'd0;
        pp_is_hdr   = 1'b0;
        pp_is_end   = 1'b0;
        pp_seen_hdr = 1'b0;
        pp_code     = REASON_NO_IEND;
    endtask

    task automatic parser_take(input logic [7:0] b);
        logic [1:0] k;
        k = pp_cnt[1:0];
        case (pp_phase)
            ST_SIG: begin
                if (b != PNG_SIG[63 - 8 * pp_cnt -: 8]) begin
                    pp_phase = ST_FAIL;
                    pp_code  = REASON_BAD_SIG;
                end else if (pp_cnt == 3'd7) begin
                    pp_phase = ST_LEN;
                    pp_cnt   = 3'd0;
                end else begin
                    pp_cnt = pp_cnt + 3'd1;
                end
            end
            ST_LEN: begin
                pp_len = {pp_len[23:0], b};
                if (k == 2'd3) begin
                    pp_phase = ST_TYPE;
                    pp_cnt   = 3'd0;
                    pp_crc   = CRC_INIT;
                end else begin
                    pp_cnt = pp_cnt + 3'd1;
                end
            end
            ST_TYPE: begin
                pp_crc = crc32_next(pp_crc, b);
                if (k == 2'd0) begin
                    pp_is_hdr = (b == NAME_IHDR[31:24]);
                    pp_is_end = (b == NAME_IEND[31:24]);
                end else begin
                    pp_is_hdr = pp_is_hdr && (b == NAME_IHDR[31 - 8 * k -: 8]);
                    pp_is_end = pp_is_end && (b == NAME_IEND[31 - 8 * k -: 8]);
                end
                if (k == 2'd3) begin
                    pp_cnt   = 3'd0;
                    pp_phase = (pp_len == 32'd0) ? ST_CRC : ST_DATA;
                end else begin
                    pp_cnt = pp_cnt + 3'd1;
                end
            end
            ST_DATA: begin
                pp_crc = crc32_next(pp_crc, b);
                pp_len = pp_len - 32'd1;
                if (pp_len == 32'd0) begin
                    pp_phase = ST_CRC;
                    pp_cnt   = 3'd0;
                end
            end
            ST_CRC: begin
                pp_stored = {pp_stored[23:0], b};
                if (k == 2'd3) begin
                    pp_cnt = 3'd0;
                    if (~pp_crc != pp_stored) begin
                        pp_phase = ST_FAIL;
                        pp_code  = REASON_CRC_FAIL;
                    end else begin
                        if (pp_is_hdr) pp_seen_hdr = 1'b1;
                        if (pp_is_end) begin
                            pp_phase = ST_DONE;
                            pp_code  = pp_seen_hdr ? REASON_OK : REASON_NO_IHDR;
                        end else begin
                            pp_phase  = ST_LEN;
                            pp_len    = 32'd0;
                            pp_stored = 32'd0;
                        end
                    end
                end else begin
                    pp_cnt = pp_cnt + 3'd1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_verdict(input logic [7:0] b, input logic is_last);
        verdict_t v;
        if (pp_phase != ST_DONE && pp_phase != ST_FAIL) live_bytes++;
        parser_take(b);
        if (is_last) begin
            if (pp_phase == ST_SIG)
                v.reason = REASON_BAD_SIG;
            else if (pp_phase inside {ST_LEN, ST_TYPE, ST_DATA, ST_CRC})
                v.reason = REASON_NO_IEND;
            else
                v.reason = pp_code;
            v.is_png = (v.reason == REASON_OK);
            verdict_q.insert(verdict_q.size(), v);
            parser_clear();
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // each byte is predicted at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_verdict(b, is_last);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_verdicts_done();
        release_input();
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic file_begin();
        file_bytes.delete();
        for (int i = 0; i < 8; i++) append_byte(PNG_SIG[63 - 8 * i -: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] name, input int unsigned len, input bit bad_crc);
        logic [31:0] crc;
        logic [31:0] len_v;
        logic [7:0]  d;
        crc   = CRC_INIT;
        len_v = len;
        for (int i = 3; i >= 0; i--) append_byte(len_v[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) begin
            append_byte(name[8 * i +: 8]);
            crc = crc32_next(crc, name[8 * i +: 8]);
        end
        for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(7, 0))
                0:       d = 8'h00;
                1:       d = 8'hFF;
                default: d = 8'($urandom_range(255, 0));
            endcase
            append_byte(d);
            crc = crc32_next(crc, d);
        end
        crc = ~crc;
        if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(31, 0));
        for (int i = 3; i >= 0; i--) append_byte(crc[8 * i +: 8]);
    endtask

    task automatic send_file_prefix(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60) return $urandom_range(8, 0);
        if (r < 90) return $urandom_range(40, 9);
        if (r < 98) return $urandom_range(100, 41);
        return $urandom_range(400, 200);
    endfunction

    function automatic logic [31:0] pick_name();
        logic [31:0] near;
        near = (32'($urandom_range(255, 1))) << (8 * $urandom_range(3, 0));
        case ($urandom_range(5, 0))
            0:       return $urandom();
            1:       return NAME_IHDR ^ near;
            2:       return NAME_IEND ^ near;
            3:       return NAME_IHDR;
            default: return NAME_IDAT;
        endcase
    endfunction

    task automatic build_random_file(output int unsigned cut);
        int unsigned r;
        int unsigned n;
        int unsigned idx;
        r = $urandom_range(99, 0);
        if (r < 8) begin
            // noise, sometimes behind a partial signature
            file_bytes.delete();
            n = $urandom_range(1) ? $urandom_range(7, 1) : 0;
            for (int unsigned i = 0; i < n; i++) append_byte(PNG_SIG[63 - 8 * i -: 8]);
            n = $urandom_range(12, 1);
            for (int unsigned i = 0; i < n; i++) append_byte(8'($urandom_range(255, 0)));
        end else begin
            file_begin();
            if ($urandom_range(9, 0) != 0) add_chunk(NAME_IHDR, pick_len(), 1'b0);
            n = $urandom_range(3, 0);
            for (int unsigned i = 0; i < n; i++) add_chunk(pick_name(), pick_len(), 1'b0);
            if ($urandom_range(9, 0) != 0)
                add_chunk(NAME_IEND, ($urandom_range(7, 0) == 0) ? $urandom_range(6, 1) : 0,
                          1'b0);
            if ($urandom_range(9, 0) < 3) begin
                n = $urandom_range(4, 1);
                for (int unsigned i = 0; i < n; i++) append_byte(8'($urandom_range(255, 0)));
            end
        end
        cut = file_bytes.size();
        r = $urandom_range(99, 0);
        if (r < 14) begin
            idx = $urandom_range(file_bytes.size() - 1, 0);
            file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(7, 0));
        end else if (r < 26) begin
            cut = $urandom_range(file_bytes.size(), 1);
        end
    endtask

    task automatic test_signature_errors();
        send_byte(8'h00, 1'b1);
        send_byte(8'h89, 1'b0);
        send_byte(8'h50, 1'b1);
        send_byte(8'h89, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        file_begin();
        send_file_prefix(8);
    endtask

    task automatic test_minimal_files();
        file_begin();
        add_chunk(NAME_IHDR, 0, 1'b0);
        add_chunk(NAME_IEND, 0, 1'b0);
        send_file_prefix(file_bytes.size());
        file_begin();
        add_chunk(NAME_IHDR, 13, 1'b0);
        add_chunk(NAME_IEND, 0, 1'b0);
        append_byte(8'hFF);
        append_byte(8'h00);
        send_file_prefix(file_bytes.size());
        file_begin();
        add_chunk(NAME_IEND, 0, 1'b0);
        send_file_prefix(file_bytes.size());
    endtask

    task automatic test_chunk_errors();
        file_begin();
        add_chunk(NAME_IHDR, 2, 1'b1);
        add_chunk(NAME_IEND, 0, 1'b0);
        send_file_prefix(file_bytes.size());
        // truncated in length, type, data and crc fields, then at a chunk boundary
        file_begin();
        add_chunk(NAME_IHDR, 4, 1'b0);
        send_file_prefix(10);
        send_file_prefix(14);
        send_file_prefix(17);
        send_file_prefix(22);
        send_file_prefix(file_bytes.size());
        // largest chunk length
        file_begin();
        for (int i = 0; i < 4; i++) append_byte(8'hFF);
        for (int i = 3; i >= 0; i--) append_byte(NAME_IDAT[8 * i +: 8]);
        append_byte(8'h00);
        append_byte(8'hFF);
        send_file_prefix(file_bytes.size());
    endtask

    task automatic test_backpressure();
        wait_verdicts_done();
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255, 0)), 1'b1);
        file_begin();
        add_chunk(NAME_IHDR, 3, 1'b0);
        add_chunk(NAME_IEND, 0, 1'b0);
        send_file_prefix(file_bytes.size());
        wait_verdicts_done();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_files();
        int unsigned target;
        int unsigned cut;
        target = live_bytes + 2000;
        while (live_bytes < target) begin
            if ($urandom_range(9, 0) == 0) tx_gaps_on = !tx_gaps_on;
            if ($urandom_range(9, 0) == 0) rx_stalls_on = !rx_stalls_on;
            if ($urandom_range(49, 0) == 0) wait_verdicts_done();
            build_random_file(cut);
            send_file_prefix(cut);
        end
    endtask

    // result side ready, with random stalls and a counted long hold
    initial begin : rx_drive
        int unsigned stall_left;
        int unsigned gap;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles != 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                gap = rx_stalls_on ? pick_gap() : 0;
                if (gap != 0) begin
                    m_tready   <= 1'b0;
                    stall_left = gap - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict 0x%02h with none expected", m_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.is_png)
                    report_mismatch($sformatf("is_png %b, expected %b", m_tdata[0], want.is_png));
                if (m_tdata[3:1] !== want.reason)
                    report_mismatch($sformatf("reason %0d, expected %0d", m_tdata[3:1],
                                              want.reason));
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch($sformatf("pad bits 0x%01h, expected zero", m_tdata[7:4]));
            end
        end
    end

    initial begin
        parser_clear();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_signature_errors();
        test_minimal_files();
        test_chunk_errors();
        test_backpressure();
        test_random_files();
        wait_verdicts_done();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && verdict_q.size() == 0) begin
            $display("[png_chunk_crc_validator_core] OK");
        end else begin
            $display("[png_chunk_crc_validator_core] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/pcv_pkg.sv
sv/png_chunk_crc_validator_core.sv
test/tb_top.sv
